// ----- rtl/core/hspi_pkg.sv -----
// Shared types, constants and the arctangent table of the dead-reckoning integrator.
`default_nettype none

package hspi_pkg;

   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_LEN = 24;

   // CORDIC gain for unlimited rotations, Q1.30
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   // arctan(2^-i) in 32-bit binary angle units
   localparam logic signed [31:0] ATAN_TABLE [ATAN_LEN] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
      32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
      32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
      32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C,
      32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517,
      32'sh0000028B, 32'sh00000145, 32'sh000000A2, 32'sh00000051
   };

   // heading quadrant codes
   localparam logic [1:0] QUAD_0   = 2'd0;
   localparam logic [1:0] QUAD_90  = 2'd1;
   localparam logic [1:0] QUAD_180 = 2'd2;
   localparam logic [1:0] QUAD_270 = 2'd3;

   // data handed from one rotation cell to the next
   typedef struct packed {
      logic              valid;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } hspi_rot_type;

   // strobes from the sequencer to an axis accumulator
   typedef struct packed {
      logic capture;
      logic commit;
   } hspi_axis_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/hspi_if.sv -----
// Request and response channel interfaces of the dead-reckoning integrator.
`default_nettype none

interface hspi_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] heading;
   logic [15:0] speed;
   logic [15:0] delta_t;

   modport source (output valid, heading, speed, delta_t, input ready);
   modport sink   (input valid, heading, speed, delta_t, output ready);
endinterface

interface hspi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0]        elapsed;

   modport source (output valid, pos_x, pos_y, elapsed, input ready);
   modport sink   (input valid, pos_x, pos_y, elapsed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hspi_cell.sv -----
// One CORDIC rotation cell of the chain.
`default_nettype none

module hspi_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hspi_pkg::hspi_rot_type link_in,
   output hspi_pkg::hspi_rot_type link_out
);
   import hspi_pkg::*;

   logic               valid_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [31:0] x_in, y_in, z_in;
   logic signed [31:0] xs, ys;

   always_comb begin
      // arithmetic shift floors toward minus infinity
      xs = link_in.x >>> STAGE;
      ys = link_in.y >>> STAGE;
      if (!link_in.z[31]) begin
         x_in = link_in.x - ys;
         y_in = link_in.y + xs;
         z_in = link_in.z - ATAN_TABLE[STAGE];
      end else begin
         x_in = link_in.x + ys;
         y_in = link_in.y - xs;
         z_in = link_in.z + ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_in.valid;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign link_out.valid = valid_ff;
   assign link_out.x     = x_ff;
   assign link_out.y     = y_ff;
   assign link_out.z     = z_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hspi_axis.sv -----
// Scale and saturating accumulator for one position axis.
`default_nettype none

module hspi_axis (
   input  logic                       clock,
   input  logic                       reset,
   input  hspi_pkg::hspi_axis_ctl_type ctl,
   input  logic [31:0]                span,
   input  logic signed [31:0]         comp,
   output logic signed [31:0]         pos
);
   import hspi_pkg::*;

   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff;
   logic [31:0]        mag;
   logic signed [31:0] acc_ff, acc_in;
   logic [27:0]        rnd;
   logic [26:0]        disp;
   logic signed [32:0] sdisp, sum;

   assign mag     = comp[31] ? 32'(-comp) : 32'(comp);
   assign prod_in = 64'(span) * 64'(mag);

   always_comb begin
      // round half up on the magnitude, then drop 38 fraction bits
      rnd   = {1'b0, prod_ff[63:37]} + 28'd1;
      disp  = rnd[27:1];
      sdisp = neg_ff ? -$signed({6'b0, disp}) : $signed({6'b0, disp});
      sum   = $signed({acc_ff[31], acc_ff}) + sdisp;
      if (sum[32] != sum[31]) begin
         acc_in = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         acc_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.commit) begin
         acc_ff <= acc_in;
      end
      if (ctl.capture) begin
         prod_ff <= prod_in;
         neg_ff  <= comp[31];
      end
   end

   assign pos = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/core/heading_speed_position_integrator.sv -----
// Dead-reckoning integrator: CORDIC cell chain, axis scalers and time accumulator.
//
//   channel | dir | handshake           | payload
//   req_ch  | in  | valid/ready         | heading[15:0], speed[15:0], delta_t[15:0]
//   rsp_ch  | out | valid/ready         | pos_x[31:0] s, pos_y[31:0] s, elapsed[31:0]
//
// One request at a time; from acceptance to response a request passes the launch
// register, one register per rotation cell, the product register and the accumulator.
// The next request is taken the cycle after the result is committed to the output
// register. A stalled response holds its data; a finished product waits in its
// register until the output frees. Synchronous reset clears position and time to zero.
`default_nettype none

module heading_speed_position_integrator #(
   parameter int CORDIC_STAGES = hspi_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   hspi_req_if.sink          req_ch,
   hspi_rsp_if.source        rsp_ch
);
   import hspi_pkg::*;

   logic               busy_ff, busy_in;
   logic               launch_ff;
   logic               prod_valid_ff, prod_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        dist_ff;
   logic [1:0]         quad_ff;
   logic [15:0]        step_ff;
   logic signed [31:0] z0_ff;
   logic [31:0]        time_ff, time_in;
   logic [32:0]        time_sum;
   logic               accept, commit, capture;
   logic signed [31:0] cos_c, sin_c;
   hspi_axis_ctl_type  axis_ctl;
   hspi_rot_type       link [CORDIC_STAGES + 1];

   assign accept  = req_ch.valid && req_ch.ready;
   assign capture = link[CORDIC_STAGES].valid;
   assign commit  = prod_valid_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign busy_in       = accept ? 1'b1 : (commit ? 1'b0 : busy_ff);
   assign prod_valid_in = capture ? 1'b1 : (commit ? 1'b0 : prod_valid_ff);
   assign rsp_valid_in  = commit || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         time_ff       <= '0;
      end else begin
         busy_ff       <= busy_in;
         launch_ff     <= accept;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (commit) begin
            time_ff <= time_in;
         end
      end
      if (accept) begin
         dist_ff <= 32'(req_ch.speed) * 32'(req_ch.delta_t);
         quad_ff <= req_ch.heading[15:14];
         step_ff <= req_ch.delta_t;
         z0_ff   <= $signed({2'b00, req_ch.heading[13:0], 16'b0});
      end
   end

   // chain entry: unit vector of gain K on the +x axis
   assign link[0].valid = launch_ff;
   assign link[0].x     = CORDIC_GAIN;
   assign link[0].y     = '0;
   assign link[0].z     = z0_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      hspi_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link[i]),
         .link_out (link[i + 1])
      );
   end

   // rotate the residual result back into its quadrant
   always_comb begin
      unique case (quad_ff)
         QUAD_0: begin
            cos_c = link[CORDIC_STAGES].x;
            sin_c = link[CORDIC_STAGES].y;
         end
         QUAD_90: begin
            cos_c = -link[CORDIC_STAGES].y;
            sin_c = link[CORDIC_STAGES].x;
         end
         QUAD_180: begin
            cos_c = -link[CORDIC_STAGES].x;
            sin_c = -link[CORDIC_STAGES].y;
         end
         QUAD_270: begin
            cos_c = link[CORDIC_STAGES].y;
            sin_c = -link[CORDIC_STAGES].x;
         end
         default: begin
            cos_c = link[CORDIC_STAGES].x;
            sin_c = link[CORDIC_STAGES].y;
         end
      endcase
   end

   assign axis_ctl.capture = capture;
   assign axis_ctl.commit  = commit;

   hspi_axis u_axis_x (
      .clock (clock),
      .reset (reset),
      .ctl   (axis_ctl),
      .span  (dist_ff),
      .comp  (cos_c),
      .pos   (rsp_ch.pos_x)
   );

   hspi_axis u_axis_y (
      .clock (clock),
      .reset (reset),
      .ctl   (axis_ctl),
      .span  (dist_ff),
      .comp  (sin_c),
      .pos   (rsp_ch.pos_y)
   );

   always_comb begin
      time_sum = {1'b0, time_ff} + {17'b0, step_ff};
      time_in  = time_sum[32] ? 32'hFFFFFFFF : time_sum[31:0];
   end

   assign req_ch.ready   = !busy_ff;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.elapsed = time_ff;

endmodule

`default_nettype wire

// ----- rtl/core/hspi_checker.sv -----
// Port-level checker of the dead-reckoning integrator and its bind.
`default_nettype none

module hspi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] pos_x,
   input logic [31:0] pos_y,
   input logic [31:0] elapsed
);

   logic       req_fire, rsp_fire;
   logic [1:0] open_ff, open_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // track requests whose response has not been taken
   always_comb begin
      open_in = open_ff;
      if (req_fire && !rsp_fire) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_y)
         && $stable(elapsed))
      else $error("stalled response changed or dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while previous one is in flight");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two requests open");

endmodule

bind heading_speed_position_integrator hspi_checker u_hspi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .pos_x     (rsp_ch.pos_x),
   .pos_y     (rsp_ch.pos_y),
   .elapsed   (rsp_ch.elapsed)
);

`default_nettype wire
